[design/hsvrgb_pkg.sv]
`default_nettype none

package hsvrgb_pkg;

    // Fixed-point formats. Levels carry FRAC_BITS fraction bits; hue carries
    // HUE_FRAC_BITS fraction bits of a degree.
    localparam int FRAC_BITS     = 12;
    localparam int HUE_FRAC_BITS = 6;

    localparam int HUE_W  = 16;
    localparam int LVL_W  = 13;
    localparam int BYTE_W = 8;

    localparam int ONE       = 1 << FRAC_BITS;
    localparam int W60       = 60 << HUE_FRAC_BITS;
    localparam int FULL_TURN = 6 * W60;

    // Internal widths.
    localparam int CLV_W   = FRAC_BITS + 1;
    localparam int HW_W    = $clog2(FULL_TURN);
    localparam int T_W     = $clog2(W60 + 1);
    localparam int VK_W    = FRAC_BITS + BYTE_W;
    localparam int SUM_W   = FRAC_BITS + T_W;
    localparam int PROD_W  = VK_W + SUM_W;
    localparam int MNUM_W  = VK_W + CLV_W;
    localparam int WRAP_W  = HUE_W + 4;

    // W60 is 15 * 2^(HUE_FRAC_BITS + 2), so the division by the full scale
    // splits into a shift and an exact division by fifteen.
    localparam int DIV_SHIFT   = 2 * FRAC_BITS + HUE_FRAC_BITS + 2;
    localparam int Q_W         = $clog2(255 * 15 + 1);
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = (1 << RECIP_SHIFT) / 15 + 1;
    localparam int XP_W        = Q_W + $clog2(RECIP + 1);

    localparam logic signed [WRAP_W-1:0] FULL_S  = WRAP_W'(FULL_TURN);
    localparam logic signed [WRAP_W-1:0] FULL2_S = WRAP_W'(2 * FULL_TURN);

    // Hue sectors, 60 degrees each.
    localparam logic [2:0] SECT_RY = 3'd0;
    localparam logic [2:0] SECT_YG = 3'd1;
    localparam logic [2:0] SECT_GC = 3'd2;
    localparam logic [2:0] SECT_CB = 3'd3;
    localparam logic [2:0] SECT_BM = 3'd4;
    localparam logic [2:0] SECT_MR = 3'd5;

    typedef logic [2:0] t_sector;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue;
        logic [LVL_W-1:0]        saturation;
        logic [LVL_W-1:0]        brightness;
        logic [LVL_W-1:0]        opacity;
    } t_hsv;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha_out;
    } t_rgba;

    // Front end result: sector, ramp position and the level terms.
    typedef struct packed {
        t_sector           sector;
        logic [T_W-1:0]    ramp;
        logic [CLV_W-1:0]  sat;
        logic [CLV_W-1:0]  one_minus_sat;
        logic [VK_W-1:0]   val_x255;
        logic [BYTE_W-1:0] alpha;
    } t_front;

    // Back end result: quotient before the divide by fifteen and finished bytes.
    typedef struct packed {
        t_sector           sector;
        logic [Q_W-1:0]    mix_q;
        logic [BYTE_W-1:0] chroma_byte;
        logic [BYTE_W-1:0] floor_byte;
        logic [BYTE_W-1:0] alpha;
    } t_back;

    function automatic logic [CLV_W-1:0] clamp_level(input logic [LVL_W-1:0] lvl);
        logic [CLV_W-1:0] res;
        if (int'(lvl) > ONE) begin
            res = CLV_W'(ONE);
        end else begin
            res = CLV_W'(lvl);
        end
        return res;
    endfunction

    function automatic logic [HW_W-1:0] sector_base(input t_sector k);
        return HW_W'(int'(k) * W60);
    endfunction

endpackage

`default_nettype wire

[design/hsvrgb_front.sv]
`default_nettype none

// Two register stages: hue wrap and level clamping, then sector split,
// ramp position and the level scaling terms.
module hsvrgb_front (
    input  wire logic              i_clk,
    input  wire logic [1:0]        i_en,
    input  wire hsvrgb_pkg::t_hsv  i_pixel,
    output hsvrgb_pkg::t_front     o_front
);

    logic signed [hsvrgb_pkg::WRAP_W-1:0] w_h;
    logic signed [hsvrgb_pkg::WRAP_W-1:0] w_hp1;
    logic signed [hsvrgb_pkg::WRAP_W-1:0] w_hp2;
    logic signed [hsvrgb_pkg::WRAP_W-1:0] w_hm1;
    logic signed [hsvrgb_pkg::WRAP_W-1:0] w_wrap;

    logic [hsvrgb_pkg::HW_W-1:0]  r_hw;
    logic [hsvrgb_pkg::CLV_W-1:0] r_sat;
    logic [hsvrgb_pkg::CLV_W-1:0] r_val;
    logic [hsvrgb_pkg::CLV_W-1:0] r_alp;

    hsvrgb_pkg::t_sector            w_sector;
    logic [hsvrgb_pkg::HW_W-1:0]    w_off;
    logic [hsvrgb_pkg::T_W-1:0]     w_f;
    logic [hsvrgb_pkg::VK_W-1:0]    w_alpha_x255;
    hsvrgb_pkg::t_front             n_front;
    hsvrgb_pkg::t_front             r_front;

    // Stage one: the input hue spans less than two turns on either side.
    assign w_h   = hsvrgb_pkg::WRAP_W'(i_pixel.hue);
    assign w_hp1 = w_h + hsvrgb_pkg::FULL_S;
    assign w_hp2 = w_h + hsvrgb_pkg::FULL2_S;
    assign w_hm1 = w_h - hsvrgb_pkg::FULL_S;

    always_comb begin
        if (w_h < 0) begin
            w_wrap = (w_hp1 < 0) ? w_hp2 : w_hp1;
        end else if (w_h >= hsvrgb_pkg::FULL_S) begin
            w_wrap = w_hm1;
        end else begin
            w_wrap = w_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_hw  <= w_wrap[hsvrgb_pkg::HW_W-1:0];
            r_sat <= hsvrgb_pkg::clamp_level(i_pixel.saturation);
            r_val <= hsvrgb_pkg::clamp_level(i_pixel.brightness);
            r_alp <= hsvrgb_pkg::clamp_level(i_pixel.opacity);
        end
    end

    // Stage two: a hue exactly on a boundary belongs to the upper sector.
    always_comb begin
        w_sector = hsvrgb_pkg::SECT_RY;
        for (int k = 1; k < 6; k++) begin
            if (r_hw >= hsvrgb_pkg::sector_base(3'(k))) begin
                w_sector = 3'(k);
            end
        end
    end

    assign w_off        = r_hw - hsvrgb_pkg::sector_base(w_sector);
    assign w_f          = w_off[hsvrgb_pkg::T_W-1:0];
    assign w_alpha_x255 = hsvrgb_pkg::VK_W'(r_alp) * hsvrgb_pkg::VK_W'(255);

    always_comb begin
        n_front.sector        = w_sector;
        n_front.ramp          = w_sector[0] ? (hsvrgb_pkg::T_W'(hsvrgb_pkg::W60) - w_f) : w_f;
        n_front.sat           = r_sat;
        n_front.one_minus_sat = hsvrgb_pkg::CLV_W'(hsvrgb_pkg::ONE) - r_sat;
        n_front.val_x255      = hsvrgb_pkg::VK_W'(r_val) * hsvrgb_pkg::VK_W'(255);
        n_front.alpha         = w_alpha_x255[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::BYTE_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

`default_nettype wire

[design/hsvrgb_back.sv]
`default_nettype none

// Two register stages: the mixed level sum and the floor term, then the wide
// product whose top bits still need a division by fifteen.
module hsvrgb_back (
    input  wire logic                i_clk,
    input  wire logic [1:0]          i_en,
    input  wire hsvrgb_pkg::t_front  i_front,
    output hsvrgb_pkg::t_back        o_back
);

    logic [hsvrgb_pkg::SUM_W-1:0]  w_sum;
    logic [hsvrgb_pkg::MNUM_W-1:0] w_mnum;

    logic [hsvrgb_pkg::SUM_W-1:0]  r_sum;
    logic [hsvrgb_pkg::VK_W-1:0]   r_vk;
    hsvrgb_pkg::t_sector           r_sector;
    logic [hsvrgb_pkg::BYTE_W-1:0] r_cbyte;
    logic [hsvrgb_pkg::BYTE_W-1:0] r_mbyte;
    logic [hsvrgb_pkg::BYTE_W-1:0] r_alpha;

    logic [hsvrgb_pkg::PROD_W-1:0] w_prod;
    hsvrgb_pkg::t_back             n_back;
    hsvrgb_pkg::t_back             r_back;

    // Stage three: s*t + (1-s)*W60 is the unscaled ramp channel over v.
    assign w_sum  = hsvrgb_pkg::SUM_W'(i_front.sat) * hsvrgb_pkg::SUM_W'(i_front.ramp)
                  + hsvrgb_pkg::SUM_W'(i_front.one_minus_sat)
                    * hsvrgb_pkg::SUM_W'(hsvrgb_pkg::W60);
    assign w_mnum = hsvrgb_pkg::MNUM_W'(i_front.val_x255)
                  * hsvrgb_pkg::MNUM_W'(i_front.one_minus_sat);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sum    <= w_sum;
            r_vk     <= i_front.val_x255;
            r_sector <= i_front.sector;
            r_cbyte  <= i_front.val_x255[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::BYTE_W];
            r_mbyte  <= w_mnum[2 * hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::BYTE_W];
            r_alpha  <= i_front.alpha;
        end
    end

    // Stage four.
    assign w_prod = hsvrgb_pkg::PROD_W'(r_vk) * hsvrgb_pkg::PROD_W'(r_sum);

    always_comb begin
        n_back.sector      = r_sector;
        n_back.mix_q       = w_prod[hsvrgb_pkg::DIV_SHIFT +: hsvrgb_pkg::Q_W];
        n_back.chroma_byte = r_cbyte;
        n_back.floor_byte  = r_mbyte;
        n_back.alpha       = r_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_back <= n_back;
        end
    end

    assign o_back = r_back;

endmodule

`default_nettype wire

[design/hsv_to_rgb_converter_core.sv]
`default_nettype none

// HSV to RGBA pixel converter.
// The input channel (i_valid, o_ready, i_pixel) carries one HSV pixel per
// transfer: a signed hue in 1/64 degree units, wrapped into 0 to 360 degrees,
// and Q12 saturation, value and alpha, each clamped to 1.0. The output channel
// (o_valid, i_ready, o_pixel) carries one RGBA pixel per transfer, each channel
// the exact floor of the level times 255.
// A pixel passes through the front module's stages, the back module's stages and
// the output register. Throughput is one pixel per cycle while the receiver
// keeps i_ready high, since each of the five register stages can hand its pixel
// on and take the next one in the same cycle.
// Every stage carries its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stalled receiver freezes only the occupied part
// of the pipeline and empty stages keep filling: up to five pixels can sit in
// the block while the receiver holds i_ready low, and nothing is dropped or
// repeated. Reset (synchronous, active low) empties all stages; the block has
// no other state and accepts a pixel as soon as reset is released.
module hsv_to_rgb_converter_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire hsvrgb_pkg::t_hsv  i_pixel,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output hsvrgb_pkg::t_rgba      o_pixel
);

    localparam int NSTG = 5;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   w_rdy;

    hsvrgb_pkg::t_front w_front;
    hsvrgb_pkg::t_back  w_back;

    logic [hsvrgb_pkg::XP_W-1:0]   w_xp;
    logic [hsvrgb_pkg::BYTE_W-1:0] w_xbyte;
    hsvrgb_pkg::t_rgba             n_pixel;
    hsvrgb_pkg::t_rgba             r_pixel;

    // A stage can take new data when it is empty or its content moves on.
    always_comb begin
        w_rdy[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    hsvrgb_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_rdy[1:0]),
        .i_pixel (i_pixel),
        .o_front (w_front)
    );

    hsvrgb_back u_back (
        .i_clk   (i_clk),
        .i_en    (w_rdy[3:2]),
        .i_front (w_front),
        .o_back  (w_back)
    );

    // Last stage: the ramp channel's quotient is divided by fifteen with a
    // reciprocal multiply, exact for every quotient the product can give.
    assign w_xp    = hsvrgb_pkg::XP_W'(w_back.mix_q) * hsvrgb_pkg::XP_W'(hsvrgb_pkg::RECIP);
    assign w_xbyte = w_xp[hsvrgb_pkg::RECIP_SHIFT +: hsvrgb_pkg::BYTE_W];

    // The sector picks which channel gets the chroma, the ramp and the floor.
    always_comb begin
        n_pixel.alpha_out = w_back.alpha;
        unique case (w_back.sector)
            hsvrgb_pkg::SECT_RY: begin
                n_pixel.red   = w_back.chroma_byte;
                n_pixel.green = w_xbyte;
                n_pixel.blue  = w_back.floor_byte;
            end
            hsvrgb_pkg::SECT_YG: begin
                n_pixel.red   = w_xbyte;
                n_pixel.green = w_back.chroma_byte;
                n_pixel.blue  = w_back.floor_byte;
            end
            hsvrgb_pkg::SECT_GC: begin
                n_pixel.red   = w_back.floor_byte;
                n_pixel.green = w_back.chroma_byte;
                n_pixel.blue  = w_xbyte;
            end
            hsvrgb_pkg::SECT_CB: begin
                n_pixel.red   = w_back.floor_byte;
                n_pixel.green = w_xbyte;
                n_pixel.blue  = w_back.chroma_byte;
            end
            hsvrgb_pkg::SECT_BM: begin
                n_pixel.red   = w_xbyte;
                n_pixel.green = w_back.floor_byte;
                n_pixel.blue  = w_back.chroma_byte;
            end
            default: begin
                n_pixel.red   = w_back.chroma_byte;
                n_pixel.green = w_back.floor_byte;
                n_pixel.blue  = w_xbyte;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NSTG-1]) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_pixel = r_pixel;

    // An accepted transfer always lands in the first stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted pixel missing from first stage");

    // A stage holding a pixel that cannot move keeps it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_vld & $past(r_vld & ~w_rdy[NSTG:1])) == $past(r_vld & ~w_rdy[NSTG:1])))
        else $error("stalled stage lost its pixel");

    // The first stage only fills from an accepted transfer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vld[0] && !i_valid) |=> !r_vld[0])
        else $error("first stage filled without a transfer");

endmodule

`default_nettype wire

[sim/hsv_to_rgb_converter_checker.sv]
`default_nettype none

// Watches both channels of the converter, predicts every output pixel from
// the input transfers and compares each output transfer against the oldest
// prediction, channel by channel.
module hsv_to_rgb_converter_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire hsvrgb_pkg::t_hsv  i_in_pixel,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire hsvrgb_pkg::t_rgba i_out_pixel,
    output int                     o_mismatches,
    output int                     o_outstanding
);
    import hsvrgb_pkg::*;

    t_rgba expected_pixels[$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    function automatic logic [BYTE_W-1:0] scale_to_byte(input longint unsigned num,
                                                        input longint unsigned den);
        longint unsigned q;
        q = (num * 255) / den;
        return (q > 255) ? 8'd255 : q[BYTE_W-1:0];
    endfunction

    // Exact rational form: everything is scaled by ONE*ONE*W60 so the only
    // rounding is the final floor of each channel.
    function automatic t_rgba hsv_to_rgba(input t_hsv px);
        longint unsigned one_q, w, den, s, v, a, f, t, c, x, m, rr, gg, bb;
        longint          hw;
        t_sector         k;
        t_rgba           res;
        one_q = longint'(ONE);
        w     = longint'(W60);
        hw    = longint'(px.hue) % longint'(FULL_TURN);
        if (hw < 0) begin
            hw = hw + longint'(FULL_TURN);
        end
        k = t_sector'(hw / longint'(W60));
        f = longint'(hw % longint'(W60));
        t = k[0] ? (w - f) : f;
        s = (longint'(px.saturation) > one_q) ? one_q : longint'(px.saturation);
        v = (longint'(px.brightness) > one_q) ? one_q : longint'(px.brightness);
        a = (longint'(px.opacity) > one_q) ? one_q : longint'(px.opacity);
        den = one_q * one_q * w;
        c   = v * s * w;
        x   = v * s * t;
        m   = v * (one_q - s) * w;
        case (k)
            SECT_RY: begin rr = c; gg = x; bb = 0; end
            SECT_YG: begin rr = x; gg = c; bb = 0; end
            SECT_GC: begin rr = 0; gg = c; bb = x; end
            SECT_CB: begin rr = 0; gg = x; bb = c; end
            SECT_BM: begin rr = x; gg = 0; bb = c; end
            default: begin rr = c; gg = 0; bb = x; end
        endcase
        res.red       = scale_to_byte(rr + m, den);
        res.green     = scale_to_byte(gg + m, den);
        res.blue      = scale_to_byte(bb + m, den);
        res.alpha_out = scale_to_byte(a, one_q);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        o_mismatches = o_mismatches + 1;
    endtask

    always @(posedge i_clk) begin
        t_rgba want;
        if (i_rst_n) begin
            // The output is retired before the input is queued; the block's
            // latency keeps a same-edge input from ever being this output.
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected pixel, red", int'(i_out_pixel.red), -1);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out_pixel.red != want.red) begin
                        report_mismatch("red", int'(i_out_pixel.red), int'(want.red));
                    end
                    if (i_out_pixel.green != want.green) begin
                        report_mismatch("green", int'(i_out_pixel.green),
                                        int'(want.green));
                    end
                    if (i_out_pixel.blue != want.blue) begin
                        report_mismatch("blue", int'(i_out_pixel.blue), int'(want.blue));
                    end
                    if (i_out_pixel.alpha_out != want.alpha_out) begin
                        report_mismatch("alpha_out", int'(i_out_pixel.alpha_out),
                                        int'(want.alpha_out));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_pixels.push_back(hsv_to_rgba(i_in_pixel));
            end
            o_outstanding = expected_pixels.size();
        end
    end

endmodule

`default_nettype wire

[sim/hsv_to_rgb_converter_core_test.sv]
`default_nettype none

// Stimulus and verdict for the HSV to RGBA converter. The checker beside the
// block does all prediction and comparison; this module only produces pixel
// transfers, paces the receiver and decides pass or fail at the end.
module hsv_to_rgb_converter_core_test;
    import hsvrgb_pkg::*;

    localparam int RANDOM_PIXELS = 2000;
    // This limit lies well beyond the slowest correct run, so it leaves a
    // wide margin before the watchdog fires.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_AFTER    = 150;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_hsv  i_pixel;
    logic  o_valid;
    logic  i_ready;
    t_rgba o_pixel;

    int    mismatches;
    int    outstanding;
    int    pixels_sent;
    int    cycles;
    logic  in_taken;
    logic  hold_done;

    hsv_to_rgb_converter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pixel (o_pixel)
    );

    hsv_to_rgb_converter_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_pixel    (i_pixel),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_pixel   (o_pixel),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // The input handshake is captured at the rising edge, so the sender,
    // which works on the falling edge, sees a settled flag telling it
    // whether its pixel was transferred.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && o_ready;
    end

    // Watchdog: a lost pixel or a stuck handshake ends the run here.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles = cycles + 1;
            if (cycles >= CYCLE_LIMIT) begin
                $display("hsv_to_rgb_converter_core verification failed");
                $finish;
            end
        end
    end

    function automatic t_hsv make_hsv(input int hue, input int sat, input int val,
                                      input int alpha);
        t_hsv p;
        p.hue        = HUE_W'(hue);
        p.saturation = LVL_W'(sat);
        p.brightness = LVL_W'(val);
        p.opacity    = LVL_W'(alpha);
        return p;
    endfunction

    // Levels are biased toward the clamp point and the ends of the field,
    // with plain uniform values filling in the rest.
    function automatic int random_level();
        int pick;
        int lvl;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       lvl = 0;
            1:       lvl = ONE;
            2:       lvl = ONE - 1;
            3:       lvl = ONE + 1;
            4:       lvl = (1 << LVL_W) - 1;
            5, 6:    lvl = $urandom_range(ONE + 1, (1 << LVL_W) - 1);
            default: lvl = $urandom_range(0, ONE);
        endcase
        return lvl;
    endfunction

    // Hue is either any 16-bit pattern or a point at or next to a sector edge,
    // possibly shifted by whole turns in either direction, then cut to 16 bits.
    function automatic int random_hue();
        int edge_pos;
        int turns;
        int hue;
        if ($urandom_range(0, 3) == 0) begin
            edge_pos = $urandom_range(0, 6) * W60 + $urandom_range(0, 2) - 1;
            turns    = $urandom_range(0, 2) - 1;
            hue      = edge_pos + turns * FULL_TURN;
        end else begin
            hue = $urandom_range(0, 65535);
        end
        return hue;
    endfunction

    // Presents one pixel and returns on the falling edge after its transfer.
    // Valid stays high from one pixel to the next when no gap follows.
    task automatic send_pixel(input t_hsv p);
        i_pixel = p;
        i_valid = 1'b1;
        do begin
            @(negedge i_clk);
        end while (!in_taken);
        pixels_sent = pixels_sent + 1;
    endtask

    task automatic idle_sender(input int n);
        i_valid = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Receiver pacing. It switches between stall patterns of random length,
    // and once, after enough pixels have gone in, refuses output for a long
    // stretch so the pipeline fills and the block has to stall its input.
    initial begin
        t_rx_mode mode;
        int       span;
        i_ready   = 1'b0;
        hold_done = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) begin
            @(negedge i_clk);
        end
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(4, 60);
            repeat (span) begin
                if (!hold_done && pixels_sent >= HOLD_AFTER) begin
                    i_ready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    RX_ALWAYS: i_ready = 1'b1;
                    RX_COIN:   i_ready = 1'($urandom_range(0, 1));
                    RX_SPARSE: i_ready = ($urandom_range(0, 7) == 0);
                    default:   i_ready = ~i_ready;
                endcase
                @(negedge i_clk);
            end
        end
    end

    initial begin
        int burst;
        int gap;
        int sent;
        pixels_sent = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_pixel     = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pixels: field extremes, every sector, the exact sector
        // boundaries, hue wrapping in both directions, clamping of all three
        // levels and zero saturation.
        send_pixel(make_hsv(0, 0, 0, 0));
        send_pixel(make_hsv(0, ONE, ONE, ONE));
        send_pixel(make_hsv(32767, 8191, 8191, 8191));
        send_pixel(make_hsv(-32768, ONE, ONE, 2048));
        send_pixel(make_hsv(-1, ONE, ONE, ONE + 1));
        send_pixel(make_hsv(W60 - 1, ONE, ONE, ONE - 1));
        send_pixel(make_hsv(W60, ONE, ONE, ONE));
        send_pixel(make_hsv(2 * W60, ONE, 3000, ONE));
        send_pixel(make_hsv(3 * W60, 3000, ONE, ONE));
        send_pixel(make_hsv(4 * W60, ONE, ONE, ONE));
        send_pixel(make_hsv(5 * W60, 2500, 3500, 100));
        send_pixel(make_hsv(FULL_TURN - 1, ONE, ONE, ONE));
        send_pixel(make_hsv(FULL_TURN, ONE, ONE, ONE));
        send_pixel(make_hsv(-FULL_TURN, ONE, ONE, ONE));
        send_pixel(make_hsv(-W60, ONE, ONE, ONE));
        send_pixel(make_hsv(W60 / 2, ONE, ONE, ONE));
        send_pixel(make_hsv(3 * W60 + W60 / 2, 2048, 2048, 2048));
        send_pixel(make_hsv(12345, 0, 2048, ONE));
        send_pixel(make_hsv(-12345, 0, 8191, 0));
        send_pixel(make_hsv(7000, 8191, 0, ONE));
        send_pixel(make_hsv(7000, ONE + 1, ONE + 1, ONE + 1));
        send_pixel(make_hsv(20000, 1, 1, 1));
        idle_sender(3);

        // Random pixels in bursts. Long bursts with no gap keep the block
        // running at full rate if i_ready allows; short gaps hit all stages.
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(1, 12);
            repeat (burst) begin
                send_pixel(make_hsv(random_hue(), random_level(), random_level(),
                                    random_level()));
                sent = sent + 1;
            end
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                idle_sender(gap);
            end
        end
        i_valid = 1'b0;

        // Drain: wait for every predicted pixel, then keep the clock running so
        // that a stray extra output would still be caught.
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("hsv_to_rgb_converter_core verification clean");
        end else begin
            $display("hsv_to_rgb_converter_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
design/hsvrgb_pkg.sv
design/hsvrgb_front.sv
design/hsvrgb_back.sv
design/hsv_to_rgb_converter_core.sv
sim/hsv_to_rgb_converter_checker.sv
sim/hsv_to_rgb_converter_core_test.sv
